### rtl/tpfv_pkg.sv
// Shared types and constants for the two-part frame validator.
// Holds region and status codes, header offsets and the item/result structs.
// No dependencies; every other file but tpfv_if.sv refers to it by scoped names.
package tpfv_pkg;

    // Header layout
    localparam logic [4:0] HEADER_BYTES   = 5'd21;
    localparam logic [4:0] MAGIC_BYTES    = 5'd4;
    localparam logic [4:0] VERSION_OFFSET = 5'd4;
    localparam logic [4:0] TEXT_OFFSET    = 5'd5;
    localparam logic [4:0] BINARY_OFFSET  = 5'd13;
    localparam logic [4:0] LAST_HDR_BYTE  = 5'd20;
    localparam logic [2:0] ALIGN_MASK     = 3'h7;

    // Register reset values
    localparam logic [31:0] MAGIC_RESET   = 32'h424C424A;
    localparam logic [7:0]  VERSION_RESET = 8'd1;

    // Configuration port
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION = 1'b1;

    // Region codes
    localparam logic [2:0] REGION_HEADER = 3'd0;
    localparam logic [2:0] REGION_TEXT   = 3'd1;
    localparam logic [2:0] REGION_PAD    = 3'd2;
    localparam logic [2:0] REGION_BINARY = 3'd3;
    localparam logic [2:0] REGION_BEYOND = 3'd4;

    // Status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_VALID    = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_MAGIC    = 3'd3;
    localparam logic [2:0] ST_VERSION  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_SIZE     = 3'd6;
    localparam logic [2:0] ST_PADDING  = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  region;
        logic        frame_end;
        logic [2:0]  status;
        logic [63:0] text_length;
        logic [63:0] bin_length;
    } result_t;

endpackage

### rtl/tpfv_if.sv
// Request and result channel interfaces of the two-part frame validator.
// Depends on nothing but plain logic types.
interface tpfv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tpfv_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  region;
    logic        frame_end;
    logic [2:0]  status;
    logic [63:0] text_length;
    logic [63:0] bin_length;

    modport source (output valid, output byte_out, output region, output frame_end,
                    output status, output text_length, output bin_length,
                    input ready);
    modport sink   (input valid, input byte_out, input region, input frame_end,
                    input status, input text_length, input bin_length,
                    output ready);
endinterface

### rtl/tpfv_in_reg.sv
// Input register stage of the two-part frame validator.
// Depends on tpfv_pkg and tpfv_in_if.
module tpfv_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    tpfv_in_if.sink            frame_in,
    input  logic               take,
    output logic               valid,
    output tpfv_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    tpfv_pkg::in_item_t item_reg;

    assign frame_in.ready = !valid_reg || take;
    assign valid_next     = frame_in.valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            item_reg.data_byte <= frame_in.data_byte;
            item_reg.last      <= frame_in.last;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### rtl/tpfv_frame_check.sv
// Frame state and per-byte check logic of the two-part frame validator.
// Holds the configuration registers, position counter, header fields and region tracker.
// Depends on tpfv_pkg.
module tpfv_frame_check
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tpfv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tpfv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 fire,
    input  tpfv_pkg::in_item_t                   item,
    output tpfv_pkg::result_t                    result
);

    logic [31:0] magic_reg;
    logic [7:0]  version_reg;
    logic [63:0] pos_reg;
    logic [63:0] pos_next;
    logic [63:0] text_reg;
    logic [63:0] text_next;
    logic [63:0] bin_reg;
    logic [63:0] bin_next;
    logic        magic_bad_reg;
    logic        magic_bad_next;
    logic        version_bad_reg;
    logic        version_bad_next;
    logic        pad_bad_reg;
    logic        pad_bad_next;
    logic [2:0]  region_reg;
    logic [2:0]  region_next;
    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [64:0] base_reg;
    logic [64:0] base_next;

    logic [7:0]  b;
    logic        in_header;
    logic [4:0]  idx;
    logic [4:0]  text_off;
    logic [4:0]  bin_off;
    logic [2:0]  pad_len;
    logic [2:0]  region_cur;
    logic        pos_sat;
    logic        short_frame;
    logic [65:0] total;
    logic        overflow;
    logic [2:0]  status;

    assign b         = item.data_byte;
    assign idx       = pos_reg[4:0];
    assign in_header = (pos_reg[63:5] == 59'd0) && (idx < tpfv_pkg::HEADER_BYTES);
    assign text_off  = idx - tpfv_pkg::TEXT_OFFSET;
    assign bin_off   = idx - tpfv_pkg::BINARY_OFFSET;
    // padding to the next 8-byte boundary after header and text
    assign pad_len   = (3'd0 - (tpfv_pkg::HEADER_BYTES[2:0] + text_reg[2:0]))
                       & tpfv_pkg::ALIGN_MASK;
    assign pos_sat   = &pos_reg;
    assign pos_next  = pos_sat ? pos_reg : pos_reg + 64'd1;
    assign region_cur = in_header ? tpfv_pkg::REGION_HEADER : region_reg;

    always_comb
    begin
        magic_bad_next   = magic_bad_reg;
        version_bad_next = version_bad_reg;
        text_next        = text_reg;
        bin_next         = bin_reg;
        base_next        = base_reg;
        if (in_header)
        begin
            if (idx < tpfv_pkg::MAGIC_BYTES)
            begin
                if (b != magic_reg[{idx[1:0], 3'b000} +: 8])
                begin
                    magic_bad_next = 1'b1;
                end
            end
            else if (idx == tpfv_pkg::VERSION_OFFSET)
            begin
                if (b != version_reg)
                begin
                    version_bad_next = 1'b1;
                end
            end
            else if (idx < tpfv_pkg::BINARY_OFFSET)
            begin
                text_next[{text_off[2:0], 3'b000} +: 8] = b;
            end
            else
            begin
                bin_next[{bin_off[2:0], 3'b000} +: 8] = b;
            end
            // text length is complete here: round header plus text up to 8 bytes
            if (idx == tpfv_pkg::BINARY_OFFSET)
            begin
                base_next = {1'b0, text_reg} + 65'(tpfv_pkg::HEADER_BYTES)
                            + 65'(tpfv_pkg::ALIGN_MASK);
                base_next[2:0] = 3'b000;
            end
        end
        pad_bad_next = pad_bad_reg || ((region_cur == tpfv_pkg::REGION_PAD) && (b != 8'd0));
    end

    // Region tracker: one down counter for the part being walked
    always_comb
    begin
        region_next = region_reg;
        rem_next    = rem_reg;
        if (!pos_sat)
        begin
            if (in_header)
            begin
                if (idx == tpfv_pkg::LAST_HDR_BYTE)
                begin
                    priority if (text_reg != 64'd0)
                    begin
                        region_next = tpfv_pkg::REGION_TEXT;
                        rem_next    = text_reg;
                    end
                    else if (pad_len != 3'd0)
                    begin
                        region_next = tpfv_pkg::REGION_PAD;
                        rem_next    = 64'(pad_len);
                    end
                    else if (bin_next != 64'd0)
                    begin
                        region_next = tpfv_pkg::REGION_BINARY;
                        rem_next    = bin_next;
                    end
                    else
                    begin
                        region_next = tpfv_pkg::REGION_BEYOND;
                    end
                end
            end
            else
            begin
                unique case (region_reg)
                    tpfv_pkg::REGION_TEXT:
                    begin
                        rem_next = rem_reg - 64'd1;
                        if (rem_reg == 64'd1)
                        begin
                            priority if (pad_len != 3'd0)
                            begin
                                region_next = tpfv_pkg::REGION_PAD;
                                rem_next    = 64'(pad_len);
                            end
                            else if (bin_reg != 64'd0)
                            begin
                                region_next = tpfv_pkg::REGION_BINARY;
                                rem_next    = bin_reg;
                            end
                            else
                            begin
                                region_next = tpfv_pkg::REGION_BEYOND;
                            end
                        end
                    end
                    tpfv_pkg::REGION_PAD:
                    begin
                        rem_next = rem_reg - 64'd1;
                        if (rem_reg == 64'd1)
                        begin
                            if (bin_reg != 64'd0)
                            begin
                                region_next = tpfv_pkg::REGION_BINARY;
                                rem_next    = bin_reg;
                            end
                            else
                            begin
                                region_next = tpfv_pkg::REGION_BEYOND;
                            end
                        end
                    end
                    tpfv_pkg::REGION_BINARY:
                    begin
                        rem_next = rem_reg - 64'd1;
                        if (rem_reg == 64'd1)
                        begin
                            region_next = tpfv_pkg::REGION_BEYOND;
                        end
                    end
                    default:
                    begin
                        region_next = region_reg;
                    end
                endcase
            end
        end
    end

    // Verdict for the final byte
    assign short_frame = (pos_next[63:5] == 59'd0) && (pos_next[4:0] < tpfv_pkg::HEADER_BYTES);
    assign total       = {1'b0, base_reg} + {2'b00, bin_next};
    assign overflow    = (total[65:64] != 2'b00);

    always_comb
    begin
        priority if (!item.last)
        begin
            status = tpfv_pkg::ST_BUSY;
        end
        else if (short_frame)
        begin
            status = tpfv_pkg::ST_TRUNC;
        end
        else if (magic_bad_next)
        begin
            status = tpfv_pkg::ST_MAGIC;
        end
        else if (version_bad_next)
        begin
            status = tpfv_pkg::ST_VERSION;
        end
        else if (overflow)
        begin
            status = tpfv_pkg::ST_OVERFLOW;
        end
        else if (pos_next != total[63:0])
        begin
            status = tpfv_pkg::ST_SIZE;
        end
        else if (pad_bad_next)
        begin
            status = tpfv_pkg::ST_PADDING;
        end
        else
        begin
            status = tpfv_pkg::ST_VALID;
        end
    end

    always_comb
    begin
        result.byte_out    = b;
        result.region      = region_cur;
        result.frame_end   = item.last;
        result.status      = status;
        result.text_length = (status == tpfv_pkg::ST_VALID) ? text_next : 64'd0;
        result.bin_length  = (status == tpfv_pkg::ST_VALID) ? bin_next : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg       <= tpfv_pkg::MAGIC_RESET;
            version_reg     <= tpfv_pkg::VERSION_RESET;
            pos_reg         <= 64'd0;
            text_reg        <= 64'd0;
            bin_reg         <= 64'd0;
            magic_bad_reg   <= 1'b0;
            version_bad_reg <= 1'b0;
            pad_bad_reg     <= 1'b0;
            region_reg      <= tpfv_pkg::REGION_HEADER;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tpfv_pkg::CFG_MAGIC:   magic_reg   <= cfg_data[31:0];
                    tpfv_pkg::CFG_VERSION: version_reg <= cfg_data[7:0];
                    default:               magic_reg   <= magic_reg;
                endcase
            end
            if (fire)
            begin
                if (item.last)
                begin
                    pos_reg         <= 64'd0;
                    text_reg        <= 64'd0;
                    bin_reg         <= 64'd0;
                    magic_bad_reg   <= 1'b0;
                    version_bad_reg <= 1'b0;
                    pad_bad_reg     <= 1'b0;
                    region_reg      <= tpfv_pkg::REGION_HEADER;
                end
                else
                begin
                    pos_reg         <= pos_next;
                    text_reg        <= text_next;
                    bin_reg         <= bin_next;
                    magic_bad_reg   <= magic_bad_next;
                    version_bad_reg <= version_bad_next;
                    pad_bad_reg     <= pad_bad_next;
                    region_reg      <= region_next;
                end
            end
        end
    end

    // Counters that are reloaded before use
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rem_reg  <= rem_next;
            base_reg <= base_next;
        end
    end

endmodule

### rtl/tpfv_out_reg.sv
// Result register stage of the two-part frame validator.
// Depends on tpfv_pkg and tpfv_out_if.
module tpfv_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tpfv_pkg::result_t result,
    output logic              can_load,
    tpfv_out_if.source        result_out
);

    logic              valid_reg;
    logic              valid_next;
    tpfv_pkg::result_t result_reg;

    assign can_load   = !valid_reg || result_out.ready;
    assign valid_next = load || (valid_reg && !result_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign result_out.valid       = valid_reg;
    assign result_out.byte_out    = result_reg.byte_out;
    assign result_out.region      = result_reg.region;
    assign result_out.frame_end   = result_reg.frame_end;
    assign result_out.status      = result_reg.status;
    assign result_out.text_length = result_reg.text_length;
    assign result_out.bin_length  = result_reg.bin_length;

endmodule

### rtl/two_part_frame_validator.sv
// Top level of the two-part frame validator: input register, check logic, result register.
// Depends on tpfv_pkg, tpfv_in_if, tpfv_out_if, tpfv_in_reg, tpfv_frame_check, tpfv_out_reg.
//
//   channel      | dir | handshake             | payload
//   -------------+-----+-----------------------+-----------------------------------------
//   frame_in     | in  | valid / ready         | data_byte[7:0], last
//   result_out   | out | valid / ready         | byte_out, region, frame_end, status,
//                |     |                       | text_length[63:0], bin_length[63:0]
//   cfg          | in  | cfg_we (no wait)      | cfg_index[0], cfg_data[31:0]
//
// One byte request per cycle, back to back, while results drain; a request is held in
// the input register and its result in the result register. Per byte the path is a
// 64-bit increment or decrement plus, for the verdict, one 66-bit add and compare.
// Reset loads the magic and version defaults and clears pos, lengths, flags and region.
// A stalled result holds in the result register while the input register still
// takes one more byte; ready then drops until the result drains.
module two_part_frame_validator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tpfv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tpfv_pkg::CFG_DATA_W-1:0]   cfg_data,
    tpfv_in_if.sink                           frame_in,
    tpfv_out_if.source                        result_out
);

    logic               item_valid;
    tpfv_pkg::in_item_t item;
    logic               can_load;
    logic               fire;
    tpfv_pkg::result_t  result;

    // advance the held byte whenever the result register can take it
    assign fire = item_valid && can_load;

    tpfv_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .take     (fire),
        .valid    (item_valid),
        .item     (item)
    );

    // header capture, region walk and end-of-frame verdict
    tpfv_frame_check u_frame_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    tpfv_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .can_load   (can_load),
        .result_out (result_out)
    );

endmodule

### rtl/tpfv_checker.sv
// Port-level checker for the two-part frame validator, bound to the top level.
// Depends on tpfv_pkg.
module tpfv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [7:0]  byte_out,
    input logic [2:0]  region,
    input logic        frame_end,
    input logic [2:0]  status,
    input logic [63:0] text_length,
    input logic [63:0] bin_length
);

    // verdict only on the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !frame_end |-> status == tpfv_pkg::ST_BUSY)
        else $error("status set on a byte that does not end the frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && frame_end |-> status != tpfv_pkg::ST_BUSY)
        else $error("frame end without a verdict");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != tpfv_pkg::ST_VALID |-> text_length == 64'd0 && bin_length == 64'd0)
        else $error("lengths reported without a valid verdict");

    // a truncated frame ends inside the header
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == tpfv_pkg::ST_TRUNC |-> region == tpfv_pkg::REGION_HEADER)
        else $error("truncated frame ends outside the header");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(byte_out) && $stable(status))
        else $error("stalled result changed");

endmodule

bind two_part_frame_validator tpfv_checker u_tpfv_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result_out.valid),
    .ready       (result_out.ready),
    .byte_out    (result_out.byte_out),
    .region      (result_out.region),
    .frame_end   (result_out.frame_end),
    .status      (result_out.status),
    .text_length (result_out.text_length),
    .bin_length  (result_out.bin_length)
);
